// ===== rtl/mcsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcsc_pkg;
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;
  localparam logic [1:0] MODE_RD = 2'd0;
  localparam logic [1:0] MODE_WR = 2'd1;
  localparam logic [1:0] MODE_SQ = 2'd2;
  localparam logic [1:0] MODE_SS = 2'd3;
  localparam logic [9:0] MEM_COST = 10'd100;
  localparam logic [9:0] CYCLE_MAX = 10'd1023;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  set_index;
    logic [19:0] tag;
    logic        shared_elsewhere;
    logic [3:0]  sharer_count;
    logic [1:0]  new_status;
  } mcsc_in_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] line_status;
    logic       access_shared;
    logic       writeback;
    logic       bus_read;
    logic       bus_invalidate;
    logic [9:0] op_cycles;
  } mcsc_out_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_DONE} mcsc_state_t;

  typedef struct packed {
    logic clr_we;
    logic rd_en;
    logic wr_en;
    logic load_out;
    logic capture;
  } mcsc_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/mesi_cache_set_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// MESI cache set controller: tag and MESI status store of a set-associative
// cache, ways kept in recency order (way 0 LRU). Each input beat is a
// processor read/write or a snoop query/set; one result beat comes back per
// input beat. An access first reads the whole set from the synchronous set
// memory, then writes the reordered set back and loads the output register
// once that register is free. After reset a clearing pass invalidates
// every set before the first beat is taken; cfg writes are taken any time.
module mesi_cache_set_controller import mcsc_pkg::*; #(
  parameter int WAYS = 4,
  parameter int SETS = 64,
  parameter int TAG_BITS = 20
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mcsc_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output mcsc_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [8:0] cfg_block_bytes
);
  localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
  mcsc_cmd_t cmd;
  logic [AW-1:0] clr_addr;
  logic [8:0] block_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) block_bytes_r <= 9'd32;
    else if (cfg_we) block_bytes_r <= cfg_block_bytes;
  end

  mcsc_ctrl #(.SETS(SETS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .clr_addr(clr_addr)
  );

  mcsc_dp #(.WAYS(WAYS), .SETS(SETS), .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .clr_addr(clr_addr), .in_data(in_data),
    .block_bytes(block_bytes_r), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== rtl/mcsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/mcsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcsc_ctrl import mcsc_pkg::*; #(
  parameter int SETS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output mcsc_cmd_t cmd,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] clr_addr
);
  localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
  mcsc_state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd       = '0;
    in_ready  = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(SETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd_en   = 1'b1;
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        // wait until the output register is free, then write back and present
        if (!ov_r || out_ready) begin
          cmd.wr_en    = 1'b1;
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign clr_addr  = clr_r;
endmodule
`default_nettype wire

// ===== rtl/mcsc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcsc_dp import mcsc_pkg::*; #(
  parameter int WAYS = 4,
  parameter int SETS = 64,
  parameter int TAG_BITS = 20
) (
  input  wire logic      clk,
  input  wire mcsc_cmd_t cmd,
  input  wire logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] clr_addr,
  input  wire mcsc_in_t  in_data,
  input  wire logic [8:0] block_bytes,
  output mcsc_out_t      out_data
);
  localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int LW = TAG_BITS + 2;
  localparam int RW = LW * WAYS;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          st;
  } line_t;

  mcsc_in_t  req_r;
  mcsc_out_t out_r, res;
  logic [RW-1:0] rdata, wdata;
  logic [AW-1:0] in_set, req_set;
  line_t cur [WAYS];
  line_t nxt [WAYS];
  logic [TAG_BITS-1:0] tagm;
  logic found;
  logic [$clog2(WAYS+1)-1:0] fw;
  logic [1:0] prev_st;
  logic [10:0] xfer, cyc;

  assign in_set  = AW'(in_data.set_index % SETS);
  assign req_set = AW'(req_r.set_index % SETS);

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.load_out) out_r <= res;
  end

  mcsc_ram #(.WIDTH(RW), .DEPTH(SETS)) u_ram (
    .clk(clk), .we(cmd.clr_we | cmd.wr_en),
    .waddr(cmd.clr_we ? clr_addr : req_set),
    .wdata(cmd.clr_we ? '0 : wdata),
    .re(cmd.rd_en), .raddr(in_set), .rdata(rdata)
  );

  always_comb begin
    tagm  = TAG_BITS'(req_r.tag);
    found = 1'b0;
    fw    = '0;
    for (int w = 0; w < WAYS; w++) begin
      cur[w] = rdata[w*LW +: LW];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur[w].st != ST_I && cur[w].tag == tagm) begin
        found = 1'b1;
        fw = ($bits(fw))'(w);
      end
    end
    prev_st = cur[fw[$clog2(WAYS+1)-1:0] % WAYS].st;
    xfer = {3'b0, block_bytes[8:2], 1'b0};
    res  = '0;
    cyc  = '0;
    for (int w = 0; w < WAYS; w++) nxt[w] = cur[w];
    case (req_r.mode)
      MODE_RD, MODE_WR: begin
        res.hit = found;
        if (found) begin
          for (int w = 0; w < WAYS - 1; w++)
            if (w >= int'(fw)) nxt[w] = cur[w+1];
          nxt[WAYS-1] = cur[fw % WAYS];
          res.access_shared = (prev_st == ST_S);
          if (req_r.mode == MODE_WR) begin
            nxt[WAYS-1].st = ST_M;
            res.bus_invalidate = (prev_st == ST_S);
          end
          res.line_status = nxt[WAYS-1].st;
          cyc = 11'd1;
        end else begin
          res.bus_read = 1'b1;
          res.access_shared = req_r.shared_elsewhere;
          for (int w = 0; w < WAYS - 1; w++) nxt[w] = cur[w+1];
          nxt[WAYS-1].tag = tagm;
          res.writeback = (cur[0].st == ST_M);
          if (req_r.mode == MODE_RD) begin
            res.line_status = req_r.shared_elsewhere ? ST_S : ST_E;
            cyc = 11'd1 + (req_r.shared_elsewhere ? xfer : 11'(MEM_COST));
          end else begin
            res.line_status = ST_M;
            res.bus_invalidate = 1'b1;
            cyc = 11'd1 + (req_r.shared_elsewhere ?
                  xfer + {6'd0, req_r.sharer_count, 1'b0} : 11'(MEM_COST));
          end
          nxt[WAYS-1].st = res.line_status;
          if (res.writeback) cyc = cyc + 11'(MEM_COST);
        end
        res.op_cycles = (cyc > 11'(CYCLE_MAX)) ? CYCLE_MAX : cyc[9:0];
      end
      MODE_SQ: begin
        res.hit = found;
        if (found) res.line_status = prev_st;
      end
      MODE_SS: begin
        res.hit = found;
        if (found) begin
          res.line_status = req_r.new_status;
          nxt[fw % WAYS].st = req_r.new_status;
        end
      end
      default: res = '0;
    endcase
    for (int w = 0; w < WAYS; w++) wdata[w*LW +: LW] = nxt[w];
  end

  assign out_data = out_r;
endmodule
`default_nettype wire
